FILE: design/midi_note_burst_repeater_assert.svh
// Assertion macros for the note burst repeater.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef MIDI_NOTE_BURST_REPEATER_ASSERT_SVH
`define MIDI_NOTE_BURST_REPEATER_ASSERT_SVH

// Same-cycle implication.
`define MNBR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MNBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mnbr_pkg.sv
// Shared types and constants for the note burst repeater.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mnbr_pkg;

  localparam int unsigned DLY_W   = 24;  // signed queue delay in samples
  localparam int unsigned IVL_W   = 20;
  localparam int unsigned RES_W   = 7;
  localparam int unsigned MAX_RES = 64;
  localparam int unsigned MIN_IVL = 30;
  localparam int signed   DLY_MIN = -8192;

  typedef enum logic [1:0] {
    OP_BLOCK  = 2'd0,
    OP_MIDI   = 2'd1,
    OP_UNUSED = 2'd2,
    OP_FLUSH  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_BYPASS      = 2'd0,
    REG_REPEAT_MODE = 2'd1,
    REG_BURST_RATE  = 2'd2,
    REG_VEL_DECAY   = 2'd3
  } cfg_reg_e;

  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;

  // Queue entry, 43 bits
  typedef struct packed {
    logic [3:0]              ch;
    logic [6:0]              note;
    logic [6:0]              vel;
    logic                    on;
    logic signed [DLY_W-1:0] delay;
  } pend_t;

  // One result
  typedef struct packed {
    logic [7:0]  status;
    logic [6:0]  data1;
    logic [6:0]  data2;
    logic [11:0] pos;
  } res_t;

endpackage

`default_nettype wire

FILE: design/mnbr_queue.sv
// Pending event store: one write port, one registered read port.
// Depends on mnbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mnbr_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  mnbr_pkg::pend_t               wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output mnbr_pkg::pend_t               rdata_o
);

  mnbr_pkg::pend_t mem [DEPTH];
  mnbr_pkg::pend_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/midi_note_burst_repeater.sv
// Note burst repeater top level: sequencer, config registers, output stage.
// Depends on mnbr_pkg, mnbr_queue and midi_note_burst_repeater_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

// One request at a time. A MIDI message passes through S_EMIT and S_FIN; a rolled
// note-on also pushes a note-off, then per repeat hit does a multiply, an 11-step
// restoring divider for the faded velocity and two queue writes. A block start or
// flush walks the queue one entry at a time, a read then an evaluate state per entry
// over the registered-read pending store. Each emitted event waits for the output
// register, which is held one event behind so that tlast lands on the last.

module midi_note_burst_repeater #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [8:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // block_len[12:0], beat_samples[33:13], in_status[41:34], in_data1[48:42],
  // in_data2[55:49], sample_pos[67:56], roll[68], random_count[71:69]
  input  wire logic [71:0] s_axis_tdata_i,
  // op[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // out_status[7:0], out_data1[14:8], out_data2[21:15], out_pos[33:22], zero pad
  output logic [39:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DW    = mnbr_pkg::DLY_W;

  typedef enum logic [3:0] {
    S_IDLE, S_AGE_RD, S_AGE_EV, S_FL_RD, S_FL_EV, S_EMIT, S_FIN,
    S_PUSH_OFF0, S_MUL, S_DIV, S_PUSH_ON, S_PUSH_OFF
  } state_e;

  // config
  logic       bypass_q;
  logic [2:0] mode_q;
  logic [1:0] rate_q;
  logic signed [8:0] decay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b0;
      mode_q   <= 3'd2;
      rate_q   <= 2'd1;
      decay_q  <= -9'sd51;
    end else if (cfg_we_i) begin
      case (mnbr_pkg::cfg_reg_e'(cfg_idx_i))
        mnbr_pkg::REG_BYPASS:      bypass_q <= cfg_data_i[0];
        mnbr_pkg::REG_REPEAT_MODE: mode_q   <= cfg_data_i[2:0];
        mnbr_pkg::REG_BURST_RATE:  rate_q   <= cfg_data_i[1:0];
        mnbr_pkg::REG_VEL_DECAY:   decay_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // input fields
  logic [1:0]  in_op;
  logic [12:0] in_blen;
  logic [20:0] in_beat;
  logic [7:0]  in_st;
  logic [6:0]  in_d1, in_d2;
  logic [11:0] in_spos;
  logic        in_roll;
  logic [2:0]  in_rcnt;

  assign in_op   = s_axis_tuser_i;
  assign in_blen = s_axis_tdata_i[12:0];
  assign in_beat = s_axis_tdata_i[33:13];
  assign in_st   = s_axis_tdata_i[41:34];
  assign in_d1   = s_axis_tdata_i[48:42];
  assign in_d2   = s_axis_tdata_i[55:49];
  assign in_spos = s_axis_tdata_i[67:56];
  assign in_roll = s_axis_tdata_i[68];
  assign in_rcnt = s_axis_tdata_i[71:69];

  state_e state_q, ret_q;
  logic [CNT_W-1:0] cnt_q, idx_q, wr_q;
  logic [mnbr_pkg::RES_W-1:0] n_q;
  logic [mnbr_pkg::IVL_W-1:0] ivl_q;
  logic [12:0] blen_q;
  logic [3:0]  ch_q;
  logic [6:0]  note_q, d2_q;
  logic [11:0] spos_q;
  logic [3:0]  rep_q;
  logic [2:0]  k_q;
  logic signed [13:0] acc_q;
  logic signed [DW-1:0] on_d_q;
  logic [10:0] quo_q;
  logic [2:0]  rem_q;
  logic [3:0]  dcnt_q;
  mnbr_pkg::res_t cand_q, hold_q, out_q;
  logic hold_v_q, out_v_q, out_last_q;

  mnbr_pkg::pend_t rd_data, wr_data;
  logic            mem_we;
  logic [IDX_W-1:0] mem_waddr;

  mnbr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wr_data),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  // aging of the entry just read
  logic signed [DW:0]   blen_s, nd_full, age_pos;
  logic signed [DW-1:0] nd;
  logic                 due;
  logic [12:0]          pos13;
  logic [11:0]          pos12;

  assign blen_s  = $signed({12'd0, blen_q});
  assign nd_full = $signed({rd_data.delay[DW-1], rd_data.delay}) - blen_s;
  assign nd      = (nd_full < (DW+1)'(mnbr_pkg::DLY_MIN)) ? DW'(mnbr_pkg::DLY_MIN)
                                                          : nd_full[DW-1:0];
  assign due     = (nd <= 0) && (n_q < mnbr_pkg::RES_W'(mnbr_pkg::MAX_RES));
  assign age_pos = $signed({nd[DW-1], nd}) + blen_s;

  always_comb begin
    if (age_pos < 0 || blen_q == 13'd0) begin
      pos13 = 13'd0;
    end else if (age_pos > blen_s - 1) begin
      pos13 = blen_q - 13'd1;
    end else begin
      pos13 = age_pos[12:0];
    end
    pos12 = (pos13 > 13'd4095) ? 12'd4095 : pos13[11:0];
  end

  // burst helpers
  logic [18:0] dur;
  logic [19:0] prod;
  logic [3:0]  div_r;
  logic        div_ge;
  logic [6:0]  vel;
  logic        q_room;

  assign dur    = ivl_q[19:1];
  assign prod   = 20'(d2_q) * 20'(acc_q[12:0]);
  assign div_r  = {rem_q, quo_q[10]};
  assign div_ge = div_r >= {1'b0, k_q};
  assign vel    = (quo_q > 11'd127) ? 7'd127 : (quo_q == 11'd0) ? 7'd1 : quo_q[6:0];
  assign q_room = cnt_q < CNT_W'(QUEUE_DEPTH);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q[IDX_W-1:0];
    wr_data   = rd_data;
    case (state_q)
      S_AGE_EV: begin
        mem_we        = !due;
        mem_waddr     = wr_q[IDX_W-1:0];
        wr_data.delay = nd;
      end
      S_PUSH_OFF0: begin
        mem_we  = q_room;
        wr_data = '{ch: ch_q, note: note_q, vel: 7'd0, on: 1'b0,
                    delay: DW'(spos_q) + DW'(dur)};
      end
      S_PUSH_ON: begin
        mem_we  = q_room;
        wr_data = '{ch: ch_q, note: note_q, vel: vel, on: 1'b1, delay: on_d_q};
      end
      S_PUSH_OFF: begin
        mem_we  = q_room;
        wr_data = '{ch: ch_q, note: note_q, vel: 7'd0, on: 1'b0,
                    delay: on_d_q + DW'(dur)};
      end
      default: ;
    endcase
  end

  // hit count from the mode
  logic [3:0] hits;
  always_comb begin
    case (mode_q)
      3'd1:    hits = 4'd3;
      3'd2:    hits = 4'd4;
      3'd3:    hits = 4'd6;
      3'd4:    hits = 4'd8;
      3'd5:    hits = {1'b0, in_rcnt};
      default: hits = 4'd2;
    endcase
  end

  logic [19:0] ivl_new;
  always_comb begin
    case (rate_q)
      2'd1:    ivl_new = 20'(in_beat >> 3);
      2'd2:    ivl_new = 20'(in_beat >> 4);
      default: ivl_new = 20'(in_beat >> 2);
    endcase
  end

  logic out_free, rolled, out_load;
  logic [2:0] k_new;
  assign out_free = !out_v_q || m_axis_tready_i;
  assign rolled   = !bypass_q && in_st[7:4] == mnbr_pkg::ST_NOTE_ON && in_d2 != 7'd0 && in_roll;
  assign k_new    = (hits >= 4'd2) ? 3'(hits - 4'd1) : 3'd0;
  assign s_axis_tready_o = state_q == S_IDLE;
  // held result moves into the output register
  assign out_load = hold_v_q && out_free && (state_q == S_EMIT || state_q == S_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_IDLE;
      cnt_q      <= '0;
      idx_q      <= '0;
      wr_q       <= '0;
      n_q        <= '0;
      ivl_q      <= mnbr_pkg::IVL_W'(mnbr_pkg::MIN_IVL);
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      rep_q      <= '0;
      k_q        <= '0;
      dcnt_q     <= '0;
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
      if (mem_we && state_q != S_AGE_EV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            n_q   <= '0;
            idx_q <= '0;
            wr_q  <= '0;
            case (mnbr_pkg::op_e'(in_op))
              mnbr_pkg::OP_BLOCK: begin
                if (!bypass_q) begin
                  ivl_q   <= (ivl_new < 20'(mnbr_pkg::MIN_IVL))
                             ? 20'(mnbr_pkg::MIN_IVL) : ivl_new;
                  blen_q  <= in_blen;
                  state_q <= S_AGE_RD;
                end
              end
              mnbr_pkg::OP_MIDI: begin
                cand_q  <= '{status: in_st, data1: in_d1, data2: in_d2, pos: in_spos};
                ch_q    <= in_st[3:0];
                note_q  <= in_d1;
                d2_q    <= in_d2;
                spos_q  <= in_spos;
                on_d_q  <= DW'(in_spos);
                k_q     <= k_new;
                rep_q   <= 4'd1;
                acc_q   <= $signed({3'd0, k_new, 8'd0}) + 14'(decay_q);
                ret_q   <= rolled ? S_PUSH_OFF0 : S_FIN;
                state_q <= S_EMIT;
              end
              mnbr_pkg::OP_FLUSH: state_q <= S_FL_RD;
              default: ;
            endcase
          end
        end
        S_AGE_RD: begin
          if (idx_q == cnt_q) begin
            cnt_q   <= wr_q;
            state_q <= S_FIN;
          end else begin
            state_q <= S_AGE_EV;
          end
        end
        S_AGE_EV: begin
          idx_q <= idx_q + 1'b1;
          if (due) begin
            cand_q.status <= {(rd_data.on ? mnbr_pkg::ST_NOTE_ON : mnbr_pkg::ST_NOTE_OFF),
                              rd_data.ch};
            cand_q.data1  <= rd_data.note;
            cand_q.data2  <= rd_data.on ? rd_data.vel : 7'd0;
            cand_q.pos    <= pos12;
            ret_q   <= S_AGE_RD;
            state_q <= S_EMIT;
          end else begin
            wr_q    <= wr_q + 1'b1;
            state_q <= S_AGE_RD;
          end
        end
        S_FL_RD: begin
          if (idx_q == cnt_q) begin
            cnt_q   <= '0;
            state_q <= S_FIN;
          end else begin
            state_q <= S_FL_EV;
          end
        end
        S_FL_EV: begin
          idx_q <= idx_q + 1'b1;
          if (rd_data.on && n_q < mnbr_pkg::RES_W'(mnbr_pkg::MAX_RES)) begin
            cand_q <= '{status: {mnbr_pkg::ST_NOTE_OFF, rd_data.ch}, data1: rd_data.note,
                        data2: 7'd0, pos: 12'd0};
            ret_q   <= S_FL_RD;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_FL_RD;
          end
        end
        S_EMIT: begin
          // hold stage keeps one result back until we know which is last
          if (!hold_v_q || out_free) begin
            if (hold_v_q) begin
              out_q      <= hold_q;
              out_last_q <= 1'b0;
            end
            hold_q   <= cand_q;
            hold_v_q <= 1'b1;
            n_q      <= n_q + 1'b1;
            state_q  <= ret_q;
          end
        end
        S_FIN: begin
          if (!hold_v_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_q      <= hold_q;
            out_last_q <= 1'b1;
            hold_v_q   <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        S_PUSH_OFF0: begin
          state_q <= (rep_q <= {1'b0, k_q}) ? S_MUL : S_FIN;
        end
        S_MUL: begin
          quo_q   <= prod[18:8];
          rem_q   <= '0;
          dcnt_q  <= 4'd11;
          on_d_q  <= on_d_q + DW'(ivl_q);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (dcnt_q == 4'd0) begin
            state_q <= S_PUSH_ON;
          end else begin
            rem_q  <= div_ge ? 3'(div_r - {1'b0, k_q}) : div_r[2:0];
            quo_q  <= {quo_q[9:0], div_ge};
            dcnt_q <= dcnt_q - 4'd1;
          end
        end
        S_PUSH_ON: state_q <= S_PUSH_OFF;
        S_PUSH_OFF: begin
          acc_q   <= acc_q + 14'(decay_q);
          rep_q   <= rep_q + 4'd1;
          state_q <= (rep_q < {1'b0, k_q}) ? S_MUL : S_FIN;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {6'd0, out_q.pos, out_q.data2, out_q.data1, out_q.status};

`include "midi_note_burst_repeater_assert.svh"

  `MNBR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(QUEUE_DEPTH), "queue count past depth")
  `MNBR_ASSERT_NOW(a_ready_hold, s_axis_tready_o, !hold_v_q, "ready with a result held")
  `MNBR_ASSERT_NOW(a_wr_behind, state_q == S_AGE_EV, wr_q <= idx_q, "write-back ahead of read")
  `MNBR_ASSERT_NEXT(a_res_limit, state_q == S_EMIT && n_q == 7'd64, 1'b0, "result limit passed")

endmodule

`default_nettype wire
